// ===== design/ltq_pkg.sv =====
// ----------------------------------------------------------------------------
// ltq_pkg
// Shared constants, codes and controller/datapath interface types for the
// last trigger time query block.
// ----------------------------------------------------------------------------
package ltq_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int MAX_TIMES_DEF   = 16;

  // Input operation codes
  localparam logic [2:0] OP_QUERY   = 3'd0;
  localparam logic [2:0] OP_APP_BT  = 3'd1;
  localparam logic [2:0] OP_APP_ON  = 3'd2;
  localparam logic [2:0] OP_APP_MO  = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  // Trigger sources
  localparam logic [1:0] SRC_BEAT   = 2'd0;
  localparam logic [1:0] SRC_ONSET  = 2'd1;
  localparam logic [1:0] SRC_MOMENT = 2'd2;
  localparam logic [1:0] SRC_REPEAT = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_SRC    = 3'd0;
  localparam logic [2:0] REG_EVERY  = 3'd1;
  localparam logic [2:0] REG_FIRST  = 3'd2;
  localparam logic [2:0] REG_THR    = 3'd3;
  localparam logic [2:0] REG_KIND   = 3'd4;
  localparam logic [2:0] REG_PERIOD = 3'd5;
  localparam logic [2:0] REG_PHASE  = 3'd6;
  localparam logic [2:0] REG_MAXT   = 3'd7;

  typedef struct packed {
    logic load;
    logic set_srch;
    logic take;
    logic dec_i;
    logic div_beat;
    logic div_rep;
    logic beat_adj;
    logic beat_step;
    logic rep_init;
    logic rep_step;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic [1:0] src;
    logic       limit_zero;
    logic       count_zero;
    logic       i_zero;
    logic       le;
    logic       match;
    logic       cnt_last;
    logic       i_lt_first;
    logic       d_lt_every;
    logic       k_zero;
    logic       rep_bad;
    logic       div_done;
  } sts_t;

endpackage

// ===== design/ltq_ram.sv =====
// ----------------------------------------------------------------------------
// ltq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ltq_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ltq_div.sv =====
// ----------------------------------------------------------------------------
// ltq_div
// Restoring divider, one quotient bit per cycle: 33-bit dividend over a
// 31-bit divisor. done pulses when quotient and remainder are ready.
// ----------------------------------------------------------------------------
module ltq_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [32:0] quo,
  output logic [31:0] rem
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [32:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [30:0] dv_r, dv_nxt;
  logic [32:0] sh;
  logic [32:0] diff;
  logic        ge;

  assign sh   = {rem_r, q_r[32]};
  assign ge   = sh >= {2'b00, dv_r};
  assign diff = sh - {2'b00, dv_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      dv_nxt  = divisor;
      cnt_nxt = 6'd33;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? diff[31:0] : sh[31:0];
      q_nxt   = {q_r[31:0], ge};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = rem_r;

endmodule

// ===== design/ltq_dp.sv =====
// ----------------------------------------------------------------------------
// ltq_dp
// Datapath: configuration registers, the three time tables, walk pointer,
// result counting, the one-deep pending result and the result registers.
// ----------------------------------------------------------------------------
module ltq_dp #(
  parameter int TABLE_DEPTH = ltq_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_TIMES   = ltq_pkg::MAX_TIMES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [2:0]         in_op,
  input  logic signed [31:0] in_time_req,
  input  logic [15:0]        in_strength,
  input  logic [3:0]         in_event_code,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  input  ltq_pkg::cmd_t      cmd,
  output ltq_pkg::sts_t      sts,
  output logic               out_valid,
  output logic signed [31:0] out_fire_time,
  output logic               out_found,
  output logic               out_last
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = $clog2(MAX_TIMES + 1);
  localparam int IW = (AW > 10) ? AW : 10;

  // configuration
  logic [1:0]  src_r;
  logic [9:0]  every_r, first_r;
  logic [15:0] thr_r;
  logic [3:0]  kind_r;
  logic [30:0] period_r;
  logic signed [31:0] phase_r;
  logic [4:0]  maxt_r;
  logic        wr;

  // table fill counts
  logic [CW-1:0] bt_cnt_r, on_cnt_r, mo_cnt_r, cnt_sel;

  // query state
  logic signed [31:0] t_r;
  logic [LW-1:0] limit_r, n_r;
  logic [AW-1:0] i_r, d_r;
  logic [32:0]   k_r;
  logic [31:0]   val_r;
  logic          pend_v_r;
  logic [31:0]   pend_t_r;

  logic          ov_r, of_r, ol_r;
  logic [31:0]   ot_r;

  logic [31:0] bt_rd;
  logic [47:0] on_rd;
  logic [35:0] mo_rd;
  logic [31:0] ram_time;
  logic [9:0]  every_eff;
  logic [IW-1:0] i_ext, first_ext, every_ext, d_ext;
  logic [IW-1:0] ifirst;
  logic [LW-1:0] limit_c;
  logic [32:0] div_dvd;
  logic [30:0] div_dvs;
  logic        div_done;
  logic [32:0] div_q;
  logic [31:0] div_rm;
  logic        we_bt, we_on, we_mo;

  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r    <= ltq_pkg::SRC_BEAT;
      every_r  <= 10'd1;
      first_r  <= '0;
      thr_r    <= '0;
      kind_r   <= '0;
      period_r <= 31'd65536;
      phase_r  <= '0;
      maxt_r   <= 5'd1;
    end else if (wr) begin
      case (paddr[4:2])
        ltq_pkg::REG_SRC:    src_r    <= pwdata[1:0];
        ltq_pkg::REG_EVERY:  every_r  <= pwdata[9:0];
        ltq_pkg::REG_FIRST:  first_r  <= pwdata[9:0];
        ltq_pkg::REG_THR:    thr_r    <= pwdata[15:0];
        ltq_pkg::REG_KIND:   kind_r   <= pwdata[3:0];
        ltq_pkg::REG_PERIOD: period_r <= pwdata[30:0];
        ltq_pkg::REG_PHASE:  phase_r  <= pwdata;
        ltq_pkg::REG_MAXT:   maxt_r   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      ltq_pkg::REG_SRC:    prdata = {30'd0, src_r};
      ltq_pkg::REG_EVERY:  prdata = {22'd0, every_r};
      ltq_pkg::REG_FIRST:  prdata = {22'd0, first_r};
      ltq_pkg::REG_THR:    prdata = {16'd0, thr_r};
      ltq_pkg::REG_KIND:   prdata = {28'd0, kind_r};
      ltq_pkg::REG_PERIOD: prdata = {1'b0, period_r};
      ltq_pkg::REG_PHASE:  prdata = phase_r;
      ltq_pkg::REG_MAXT:   prdata = {27'd0, maxt_r};
      default:             prdata = '0;
    endcase
  end

  // appends land at the fill count; a full table drops them
  assign we_bt = acc && (in_op == ltq_pkg::OP_APP_BT) && (bt_cnt_r != CW'(TABLE_DEPTH));
  assign we_on = acc && (in_op == ltq_pkg::OP_APP_ON) && (on_cnt_r != CW'(TABLE_DEPTH));
  assign we_mo = acc && (in_op == ltq_pkg::OP_APP_MO) && (mo_cnt_r != CW'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bt_cnt_r <= '0;
      on_cnt_r <= '0;
      mo_cnt_r <= '0;
    end else if (acc && in_op == ltq_pkg::OP_CLEAR) begin
      bt_cnt_r <= '0;
      on_cnt_r <= '0;
      mo_cnt_r <= '0;
    end else begin
      if (we_bt) bt_cnt_r <= bt_cnt_r + CW'(1);
      if (we_on) on_cnt_r <= on_cnt_r + CW'(1);
      if (we_mo) mo_cnt_r <= mo_cnt_r + CW'(1);
    end
  end

  ltq_ram #(.W(32), .D(TABLE_DEPTH)) u_bt_ram (
    .clk(clk), .we(we_bt), .waddr(bt_cnt_r[AW-1:0]), .wdata(in_time_req),
    .raddr(i_r), .rdata(bt_rd)
  );

  ltq_ram #(.W(48), .D(TABLE_DEPTH)) u_on_ram (
    .clk(clk), .we(we_on), .waddr(on_cnt_r[AW-1:0]),
    .wdata({in_strength, in_time_req}), .raddr(i_r), .rdata(on_rd)
  );

  ltq_ram #(.W(36), .D(TABLE_DEPTH)) u_mo_ram (
    .clk(clk), .we(we_mo), .waddr(mo_cnt_r[AW-1:0]),
    .wdata({in_event_code, in_time_req}), .raddr(i_r), .rdata(mo_rd)
  );

  always_comb begin
    case (src_r)
      ltq_pkg::SRC_BEAT:   begin ram_time = bt_rd;        cnt_sel = bt_cnt_r; end
      ltq_pkg::SRC_ONSET:  begin ram_time = on_rd[31:0];  cnt_sel = on_cnt_r; end
      ltq_pkg::SRC_MOMENT: begin ram_time = mo_rd[31:0];  cnt_sel = mo_cnt_r; end
      default:             begin ram_time = val_r;        cnt_sel = '0;       end
    endcase
  end

  assign every_eff = (every_r == 10'd0) ? 10'd1 : every_r;
  assign i_ext     = IW'(i_r);
  assign d_ext     = IW'(d_r);
  assign first_ext = IW'(first_r);
  assign every_ext = IW'(every_eff);
  assign ifirst    = i_ext - first_ext;
  assign limit_c   = (32'(maxt_r) > MAX_TIMES) ? LW'(MAX_TIMES) : LW'(maxt_r);

  assign div_dvd = cmd.div_beat ? 33'(ifirst)
                                : ({t_r[31], t_r} - {phase_r[31], phase_r});
  assign div_dvs = cmd.div_beat ? 31'(every_eff) : period_r;

  ltq_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_beat || cmd.div_rep),
    .dividend(div_dvd), .divisor(div_dvs),
    .done(div_done), .quo(div_q), .rem(div_rm)
  );

  // query walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r     <= in_time_req;
      limit_r <= limit_c;
      i_r     <= AW'(cnt_sel - CW'(1));
    end
    if (cmd.dec_i) i_r <= i_r - AW'(1);
    if (cmd.beat_adj) begin
      i_r <= i_r - div_rm[AW-1:0];
      d_r <= ifirst[AW-1:0] - div_rm[AW-1:0];
    end
    if (cmd.beat_step) begin
      i_r <= i_r - every_ext[AW-1:0];
      d_r <= d_r - every_ext[AW-1:0];
    end
    if (cmd.rep_init) begin
      val_r <= t_r - div_rm;
      k_r   <= div_q;
    end
    if (cmd.rep_step) begin
      val_r <= val_r - {1'b0, period_r};
      k_r   <= k_r - 33'd1;
    end
    if (cmd.take) pend_t_r <= ram_time;
  end

  // hold one result back so the final one can carry last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      n_r      <= '0;
      ov_r     <= 1'b0;
      of_r     <= 1'b0;
      ol_r     <= 1'b0;
      ot_r     <= '0;
    end else begin
      ov_r <= 1'b0;
      if (cmd.load) begin
        pend_v_r <= 1'b0;
        n_r      <= '0;
      end
      if (cmd.take) begin
        ov_r     <= pend_v_r;
        ot_r     <= pend_t_r;
        of_r     <= 1'b1;
        ol_r     <= 1'b0;
        pend_v_r <= 1'b1;
        n_r      <= n_r + LW'(1);
      end
      if (cmd.fin) begin
        ov_r     <= 1'b1;
        ot_r     <= pend_v_r ? pend_t_r : 32'd0;
        of_r     <= pend_v_r;
        ol_r     <= 1'b1;
        pend_v_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.src        = src_r;
    sts.limit_zero = (limit_r == '0);
    sts.count_zero = (cnt_sel == '0);
    sts.i_zero     = (i_r == '0);
    sts.le         = $signed(ram_time) <= t_r;
    sts.match      = (src_r == ltq_pkg::SRC_ONSET) ? (on_rd[47:32] >= thr_r)
                                                   : (mo_rd[35:32] == kind_r);
    sts.cnt_last   = (n_r + LW'(1)) == limit_r;
    sts.i_lt_first = i_ext < first_ext;
    sts.d_lt_every = d_ext < every_ext;
    sts.k_zero     = (k_r == '0);
    sts.rep_bad    = (period_r == '0) || (t_r < phase_r);
    sts.div_done   = div_done;
  end

  assign out_valid     = ov_r;
  assign out_fire_time = ot_r;
  assign out_found     = of_r;
  assign out_last      = ol_r;

endmodule

// ===== design/ltq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ltq_ctrl
// Query sequencer: backward search and walk of a table, beat stride setup
// through the divider, and the periodic repeat walk.
// ----------------------------------------------------------------------------
module ltq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [2:0]    in_op,
  output logic          busy,
  output logic          acc,
  output ltq_pkg::cmd_t cmd,
  input  ltq_pkg::sts_t sts
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_QSET = 4'd1;
  localparam logic [3:0] S_SRD  = 4'd2;
  localparam logic [3:0] S_SCHK = 4'd3;
  localparam logic [3:0] S_BDIV = 4'd4;
  localparam logic [3:0] S_BRD  = 4'd5;
  localparam logic [3:0] S_BCHK = 4'd6;
  localparam logic [3:0] S_RDIV = 4'd7;
  localparam logic [3:0] S_RWLK = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state_r, state_nxt;

  // track whether the search point has been passed in this walk
  logic srch_hit_r, srch_hit;
  assign srch_hit = srch_hit_r;

  assign busy = (state_r != S_IDLE);
  assign acc  = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (acc && in_op == ltq_pkg::OP_QUERY) begin
          cmd.load  = 1'b1;
          state_nxt = S_QSET;
        end
      end
      S_QSET: begin
        if (sts.limit_zero) begin
          state_nxt = S_FIN;
        end else if (sts.src == ltq_pkg::SRC_REPEAT) begin
          if (sts.rep_bad) begin
            state_nxt = S_FIN;
          end else begin
            cmd.div_rep = 1'b1;
            state_nxt   = S_RDIV;
          end
        end else if (sts.count_zero) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SRD;
        end
      end
      S_SRD: state_nxt = S_SCHK;
      S_SCHK: begin
        if (sts.src == ltq_pkg::SRC_BEAT) begin
          if (sts.le) begin
            if (sts.i_lt_first) begin
              state_nxt = S_FIN;
            end else begin
              cmd.div_beat = 1'b1;
              state_nxt    = S_BDIV;
            end
          end else if (sts.i_zero) begin
            state_nxt = S_FIN;
          end else begin
            cmd.dec_i = 1'b1;
            state_nxt = S_SRD;
          end
        end else begin
          // once the search point is found, lower entries are walked until the limit is met
          if (sts.le) cmd.set_srch = 1'b1;
          if ((sts.le || srch_hit) && sts.match) begin
            cmd.take = 1'b1;
          end
          if ((sts.le || srch_hit) && sts.match && sts.cnt_last) begin
            state_nxt = S_FIN;
          end else if (sts.i_zero) begin
            state_nxt = S_FIN;
          end else begin
            cmd.dec_i = 1'b1;
            state_nxt = S_SRD;
          end
        end
      end
      S_BDIV: begin
        if (sts.div_done) begin
          cmd.beat_adj = 1'b1;
          state_nxt    = S_BRD;
        end
      end
      S_BRD: state_nxt = S_BCHK;
      S_BCHK: begin
        cmd.take = 1'b1;
        if (sts.cnt_last || sts.d_lt_every) begin
          state_nxt = S_FIN;
        end else begin
          cmd.beat_step = 1'b1;
          state_nxt     = S_BRD;
        end
      end
      S_RDIV: begin
        if (sts.div_done) begin
          cmd.rep_init = 1'b1;
          state_nxt    = S_RWLK;
        end
      end
      S_RWLK: begin
        cmd.take = 1'b1;
        if (sts.cnt_last || sts.k_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rep_step = 1'b1;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      srch_hit_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load) begin
        srch_hit_r <= 1'b0;
      end else if (cmd.set_srch) begin
        srch_hit_r <= 1'b1;
      end
    end
  end

endmodule

// ===== design/last_trigger_time_query_core.sv =====
// ----------------------------------------------------------------------------
// last_trigger_time_query_core
// Keeps beat, onset and moment time tables and answers queries with the most recent
// table or periodic repeat trigger times at or before a query time, newest first.
// ----------------------------------------------------------------------------
// Channel   Handshake                     Payload
// in        start / busy                  in_op, in_time_req, in_strength,
//                                         in_event_code
// out       out_valid (one-cycle strobe)  out_fire_time, out_found, out_last
// cfg       APB psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// Appends and clear take effect at the accepting edge; busy stays low.
// A table query walks entries downward through S_SRD and S_SCHK (registered
// RAM read), from the newest entry down to the oldest walked one. A beat
// query first finds the stride remainder in the serial divider, then steps
// beats through S_BRD and S_BCHK; a repeat query runs the divider, then takes
// one cycle per result. Every query ends in S_FIN, which sends the last beat.
// Reset clears the fill counts and registers; no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module last_trigger_time_query_core #(
  parameter int TABLE_DEPTH = ltq_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_TIMES   = ltq_pkg::MAX_TIMES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_op,
  input  logic signed [31:0] in_time_req,
  input  logic [15:0]        in_strength,
  input  logic [3:0]         in_event_code,
  output logic               out_valid,
  output logic signed [31:0] out_fire_time,
  output logic               out_found,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  ltq_pkg::cmd_t cmd;
  ltq_pkg::sts_t sts;
  logic          acc;

  assign pready = 1'b1;

  ltq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_op(in_op),
    .busy(busy), .acc(acc), .cmd(cmd), .sts(sts)
  );

  ltq_dp #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_TIMES(MAX_TIMES)) u_dp (
    .clk(clk), .rst_n(rst_n), .acc(acc), .in_op(in_op),
    .in_time_req(in_time_req), .in_strength(in_strength),
    .in_event_code(in_event_code),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata),
    .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_fire_time(out_fire_time),
    .out_found(out_found), .out_last(out_last)
  );

endmodule

// ===== design/ltq_chk.sv =====
// ----------------------------------------------------------------------------
// ltq_chk
// Port-level checks on result framing and query sequencing.
// ----------------------------------------------------------------------------
module ltq_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [2:0]  in_op,
  input logic        out_valid,
  input logic [31:0] out_fire_time,
  input logic        out_found,
  input logic        out_last
);

  // a not-found beat is always the only, and final, beat of its query
  a_nf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last)
    else $error("not-found result without last");

  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_fire_time == 32'd0)
    else $error("not-found result with nonzero time");

  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result directly after final result");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start) && $past(in_op) == ltq_pkg::OP_QUERY)
    else $error("busy without an accepted query");

endmodule

bind last_trigger_time_query_core ltq_chk u_ltq_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_op(in_op),
  .out_valid(out_valid), .out_fire_time(out_fire_time),
  .out_found(out_found), .out_last(out_last)
);

// ===== tb/last_trigger_time_query_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// last_trigger_time_query_core_test
// Drives appends, clears and queries through the start/busy port, keeps its
// own copy of the three time tables and the registers, and checks every
// result beat against the trigger times predicted for each accepted query.
// Register settings change over the run through the APB-style port.
// ----------------------------------------------------------------------------
module last_trigger_time_query_core_test;

  localparam int DEPTH      = 1024;
  localparam int TIMES_CAP  = 16;
  localparam int SETTLE     = 40;
  localparam int STALL_MAX  = 20000;

  localparam logic [1:0] D_IDLE   = 2'd0;
  localparam logic [1:0] D_SEND   = 2'd1;
  localparam logic [1:0] D_SETUP  = 2'd2;
  localparam logic [1:0] D_ACCESS = 2'd3;

  typedef enum logic [1:0] {K_OP, K_CFG, K_DRAIN} kind_t;

  typedef struct {
    kind_t             kind;
    logic [2:0]        op;
    logic signed [31:0] t;
    logic [15:0]       strength;
    logic [3:0]        code;
    logic [2:0]        reg_idx;
    logic [31:0]       value;
    int                gap_pct;
  } item_t;

  typedef struct {
    logic signed [31:0] fire;
    logic               found;
    logic               last;
  } fire_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_op = ltq_pkg::OP_QUERY;
  logic signed [31:0] in_time_req = '0;
  logic [15:0] in_strength = '0;
  logic [3:0] in_event_code = '0;
  logic out_valid;
  logic signed [31:0] out_fire_time;
  logic out_found;
  logic out_last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  last_trigger_time_query_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_time_req(in_time_req), .in_strength(in_strength),
    .in_event_code(in_event_code), .out_valid(out_valid),
    .out_fire_time(out_fire_time), .out_found(out_found), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state
  logic [1:0]  m_src;
  logic [9:0]  m_every, m_first;
  logic [15:0] m_thr;
  logic [3:0]  m_kind;
  logic [30:0] m_period;
  logic signed [31:0] m_phase;
  logic [4:0]  m_maxt;
  logic signed [31:0] beat_tbl [DEPTH];
  logic signed [31:0] onset_tbl [DEPTH];
  logic [15:0] onset_str [DEPTH];
  logic signed [31:0] moment_tbl [DEPTH];
  logic [3:0]  moment_kd [DEPTH];
  int unsigned n_beats, n_onsets, n_moments;

  item_t pending_items[$];
  fire_t expected_fires[$];
  item_t cur;
  logic [1:0] drv_state = D_IDLE;
  int settle_cnt = 0;
  int errors = 0, n_queries = 0, n_appends = 0, n_fires = 0, n_cfg = 0, n_found = 0;
  int stall = 0;
  logic accepted_any;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h (fire beat %0d)", what, got, want, n_fires);
  endtask

  function automatic int unsigned newest_at_or_before(input int sel, input logic signed [31:0] t);
    int unsigned i;
    logic signed [31:0] v;
    i = (sel == 0) ? n_beats : (sel == 1) ? n_onsets : n_moments;
    while (i > 0) begin
      v = (sel == 0) ? beat_tbl[i-1] : (sel == 1) ? onset_tbl[i-1] : moment_tbl[i-1];
      if (v <= t) return i;
      i--;
    end
    return 0;
  endfunction

  function automatic void predict_fires(input logic signed [31:0] t);
    logic signed [31:0] hits[$];
    int unsigned lim, every, first, i;
    longint k;
    fire_t f;
    lim = (m_maxt > TIMES_CAP) ? TIMES_CAP : m_maxt;
    if (lim != 0) begin
      case (m_src)
        ltq_pkg::SRC_BEAT: begin
          every = (m_every == 0) ? 1 : m_every;
          first = m_first;
          i = newest_at_or_before(0, t);
          if (i != 0 && i - 1 >= first) begin
            i = i - 1;
            i -= (i - first) % every;
            while (hits.size() < lim) begin
              hits.insert(hits.size(), beat_tbl[i]);
              if (i < first + every) break;
              i -= every;
            end
          end
        end
        ltq_pkg::SRC_ONSET: begin
          i = newest_at_or_before(1, t);
          while (i > 0 && hits.size() < lim) begin
            i--;
            if (onset_str[i] >= m_thr) hits.insert(hits.size(), onset_tbl[i]);
          end
        end
        ltq_pkg::SRC_MOMENT: begin
          i = newest_at_or_before(2, t);
          while (i > 0 && hits.size() < lim) begin
            i--;
            if (moment_kd[i] == m_kind) hits.insert(hits.size(), moment_tbl[i]);
          end
        end
        default: begin
          if (m_period != 0 && t >= m_phase) begin
            k = (longint'(t) - longint'(m_phase)) / longint'(m_period);
            while (k >= 0 && hits.size() < lim) begin
              hits.insert(hits.size(), 32'(longint'(m_phase) + k * longint'(m_period)));
              k--;
            end
          end
        end
      endcase
    end
    if (hits.size() == 0) begin
      f.fire = '0; f.found = 1'b0; f.last = 1'b1;
      expected_fires.insert(expected_fires.size(), f);
    end else begin
      foreach (hits[j]) begin
        f.fire = hits[j]; f.found = 1'b1; f.last = (j == hits.size() - 1);
        expected_fires.insert(expected_fires.size(), f);
      end
    end
  endfunction

  function automatic void apply_item(input item_t it);
    case (it.op)
      ltq_pkg::OP_QUERY: begin n_queries++; predict_fires(it.t); end
      ltq_pkg::OP_APP_BT: begin
        n_appends++;
        if (n_beats < DEPTH) begin beat_tbl[n_beats] = it.t; n_beats++; end
      end
      ltq_pkg::OP_APP_ON: begin
        n_appends++;
        if (n_onsets < DEPTH) begin
          onset_tbl[n_onsets] = it.t; onset_str[n_onsets] = it.strength; n_onsets++;
        end
      end
      ltq_pkg::OP_APP_MO: begin
        n_appends++;
        if (n_moments < DEPTH) begin
          moment_tbl[n_moments] = it.t; moment_kd[n_moments] = it.code; n_moments++;
        end
      end
      ltq_pkg::OP_CLEAR: begin n_beats = 0; n_onsets = 0; n_moments = 0; end
      default: ;
    endcase
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] v);
    n_cfg++;
    case (idx)
      ltq_pkg::REG_SRC:    m_src = v[1:0];
      ltq_pkg::REG_EVERY:  m_every = v[9:0];
      ltq_pkg::REG_FIRST:  m_first = v[9:0];
      ltq_pkg::REG_THR:    m_thr = v[15:0];
      ltq_pkg::REG_KIND:   m_kind = v[3:0];
      ltq_pkg::REG_PERIOD: m_period = v[30:0];
      ltq_pkg::REG_PHASE:  m_phase = v;
      ltq_pkg::REG_MAXT:   m_maxt = v[4:0];
      default: ;
    endcase
  endfunction

  // Driver: one NBA per signal per edge, next values built in variables
  logic nx_start, nx_psel, nx_penable;
  logic free;
  item_t front;
  always @(posedge clk) begin
    if (rst_n) begin
      nx_start = start; nx_psel = psel; nx_penable = penable;
      free = 1'b0;
      case (drv_state)
        D_IDLE: free = 1'b1;
        D_SEND: if (start && !busy) begin
          apply_item(cur);
          nx_start = 1'b0; free = 1'b1; drv_state = D_IDLE;
        end
        D_SETUP: begin nx_penable = 1'b1; drv_state = D_ACCESS; end
        D_ACCESS: if (pready) begin
          apply_reg(cur.reg_idx, cur.value);
          nx_psel = 1'b0; nx_penable = 1'b0; free = 1'b1; drv_state = D_IDLE;
        end
        default: ;
      endcase
      if (free && pending_items.size() != 0) begin
        front = pending_items[0];
        if (front.kind == K_OP) begin
          settle_cnt = 0;
          if ($urandom_range(0, 99) >= front.gap_pct) begin
            cur = pending_items.pop_front();
            nx_start = 1'b1;
            in_op <= cur.op; in_time_req <= cur.t;
            in_strength <= cur.strength; in_event_code <= cur.code;
            drv_state = D_SEND;
          end
        end else if (expected_fires.size() == 0 && !busy) begin
          // hold until the block has been quiet long enough
          settle_cnt++;
          if (settle_cnt >= SETTLE) begin
            cur = pending_items.pop_front();
            settle_cnt = 0;
            if (cur.kind == K_CFG) begin
              nx_psel = 1'b1; nx_penable = 1'b0;
              pwrite <= 1'b1; paddr <= {cur.reg_idx, 2'b00}; pwdata <= cur.value;
              drv_state = D_SETUP;
            end
          end
        end else begin
          settle_cnt = 0;
        end
      end
      start <= nx_start; psel <= nx_psel; penable <= nx_penable;
    end
  end

  // Monitor
  fire_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_fires++;
      if (expected_fires.size() == 0) begin
        report("unexpected result", out_fire_time, 32'h0);
      end else begin
        want = expected_fires.pop_front();
        if (out_found) n_found++;
        if (out_found !== want.found) report("found", 32'(out_found), 32'(want.found));
        if (out_fire_time !== want.fire) report("fire_time", out_fire_time, want.fire);
        if (out_last !== want.last) report("last", 32'(out_last), 32'(want.last));
      end
    end
  end

  // Watchdog on cycles where nothing moves
  always @(posedge clk) begin
    accepted_any = (start && !busy) || out_valid || (psel && penable && pwrite && pready);
    if (!rst_n || accepted_any || pending_items.size() == 0 && expected_fires.size() == 0)
      stall <= 0;
    else if (stall >= STALL_MAX) begin
      $display("Watchdog expired after %0d idle cycles", stall);
      $display("Test completed with failures");
      $finish;
    end else
      stall <= stall + 1;
  end

  // Stimulus
  int gap = 24;
  logic signed [31:0] last_t[3];

  task automatic add_op(input logic [2:0] op, input logic signed [31:0] t,
                        input logic [15:0] s = 16'h0, input logic [3:0] c = 4'h0);
    item_t it;
    it.kind = K_OP; it.op = op; it.t = t; it.strength = s; it.code = c;
    it.reg_idx = ltq_pkg::REG_SRC; it.value = '0; it.gap_pct = gap;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic add_reg(input logic [2:0] idx, input logic [31:0] v);
    item_t it;
    it.kind = K_CFG; it.op = ltq_pkg::OP_QUERY; it.t = '0; it.strength = '0; it.code = '0;
    it.reg_idx = idx; it.value = v; it.gap_pct = 0;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic add_drain();
    item_t it;
    it.kind = K_DRAIN; it.op = ltq_pkg::OP_QUERY; it.t = '0; it.strength = '0; it.code = '0;
    it.reg_idx = ltq_pkg::REG_SRC; it.value = '0; it.gap_pct = 0;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic load_regs(input logic [1:0] src, input logic [9:0] ev, input logic [9:0] fb,
                           input logic [15:0] thr, input logic [3:0] kd,
                           input logic [30:0] per, input logic [31:0] ph, input logic [4:0] mt);
    add_reg(ltq_pkg::REG_SRC, 32'(src)); add_reg(ltq_pkg::REG_EVERY, 32'(ev));
    add_reg(ltq_pkg::REG_FIRST, 32'(fb)); add_reg(ltq_pkg::REG_THR, 32'(thr));
    add_reg(ltq_pkg::REG_KIND, 32'(kd)); add_reg(ltq_pkg::REG_PERIOD, 32'(per));
    add_reg(ltq_pkg::REG_PHASE, ph); add_reg(ltq_pkg::REG_MAXT, 32'(mt));
  endtask

  // Mostly ascending loads with random content, queries near the loaded span
  task automatic random_block(input int n);
    int r, sel;
    logic signed [31:0] t;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      sel = $urandom_range(0, 2);
      if (r < 45) begin
        t = last_t[sel] + $signed($urandom_range(0, 5 * 65536));
        last_t[sel] = t;
        add_op(3'(ltq_pkg::OP_APP_BT + sel), t, 16'($urandom), 4'($urandom));
      end else if (r < 85) begin
        t = last_t[sel] - $signed($urandom_range(0, 20 * 65536)) + 65536;
        if (r >= 80) t = $urandom;
        add_op(ltq_pkg::OP_QUERY, t, 16'($urandom), 4'($urandom));
      end else if (r < 89) begin
        add_op(ltq_pkg::OP_CLEAR, $urandom, 16'($urandom), 4'($urandom));
        t = $signed($urandom_range(0, 32'h3FFFFFFF)) - 32'sh20000000;
        last_t[0] = t; last_t[1] = t; last_t[2] = t;
      end else if (r < 95) begin
        add_op(3'(ltq_pkg::OP_APP_BT + sel), $urandom, 16'($urandom), 4'($urandom));
      end else begin
        add_op(3'($urandom_range(5, 7)), $urandom, 16'($urandom), 4'($urandom));
      end
    end
  endtask

  initial begin
    m_src = ltq_pkg::SRC_BEAT; m_every = 10'd1; m_first = '0; m_thr = '0; m_kind = '0;
    m_period = 31'd65536; m_phase = '0; m_maxt = 5'd1;
    n_beats = 0; n_onsets = 0; n_moments = 0;
    last_t[0] = 0; last_t[1] = 0; last_t[2] = 0;

    // Directed: empty tables, extreme times, every op, unused codes
    gap = 24;
    add_op(ltq_pkg::OP_QUERY, 32'sh7FFFFFFF);
    add_op(ltq_pkg::OP_APP_BT, 32'sh80000000);
    add_op(ltq_pkg::OP_APP_BT, 32'sh00010000);
    add_op(ltq_pkg::OP_APP_BT, 32'sh7FFFFFFF);
    add_op(ltq_pkg::OP_QUERY, 32'sh80000000);
    add_op(ltq_pkg::OP_QUERY, 32'sh7FFFFFFF);
    add_op(ltq_pkg::OP_APP_ON, 32'sh80000000, 16'hFFFF, 4'hF);
    add_op(ltq_pkg::OP_APP_ON, 32'sh00000000, 16'h0000, 4'h0);
    add_op(ltq_pkg::OP_APP_MO, 32'sh80000000, 16'h0000, 4'hF);
    add_op(ltq_pkg::OP_APP_MO, 32'sh7FFFFFFF, 16'hFFFF, 4'h0);
    add_op(3'd5, 32'sh7FFFFFFF, 16'hFFFF, 4'hF);
    add_op(3'd6, 32'sh0);
    add_op(3'd7, 32'sh80000000);
    load_regs(ltq_pkg::SRC_ONSET, 10'd0, 10'd0, 16'hFFFF, 4'hF, 31'd0, 32'h0, 5'd16);
    add_op(ltq_pkg::OP_QUERY, 32'sh7FFFFFFF);
    load_regs(ltq_pkg::SRC_MOMENT, 10'd1023, 10'd1023, 16'h0000, 4'hF, 31'h7FFFFFFF,
              32'h80000000, 5'd31);
    add_op(ltq_pkg::OP_QUERY, 32'sh7FFFFFFF);
    add_op(ltq_pkg::OP_QUERY, 32'sh80000000);
    load_regs(ltq_pkg::SRC_REPEAT, 10'd0, 10'd0, 16'h0, 4'h0, 31'd0, 32'h0, 5'd16);
    add_op(ltq_pkg::OP_QUERY, 32'sh7FFFFFFF);
    load_regs(ltq_pkg::SRC_REPEAT, 10'd3, 10'd1, 16'h0, 4'h0, 31'h7FFFFFFF,
              32'h80000000, 5'd16);
    add_op(ltq_pkg::OP_QUERY, 32'sh7FFFFFFF);
    add_op(ltq_pkg::OP_QUERY, 32'sh80000000);
    load_regs(ltq_pkg::SRC_BEAT, 10'd0, 10'd0, 16'h0, 4'h0, 31'd1, 32'h7FFFFFFF, 5'd0);
    add_op(ltq_pkg::OP_QUERY, 32'sh7FFFFFFF);
    add_op(ltq_pkg::OP_CLEAR, 32'sh0);
    add_op(ltq_pkg::OP_QUERY, 32'sh7FFFFFFF);

    // Random phases, each with its own register setting
    for (int ph = 0; ph < 9; ph++) begin
      gap = (ph < 3) ? 24 : (ph < 6) ? 87 : 0;
      load_regs(2'(ph % 4), 10'($urandom_range(0, 4)), 10'($urandom_range(0, 3)),
                16'($urandom), 4'($urandom_range(0, 1)),
                31'($urandom_range(1, 4) * 16384 + $urandom_range(0, 3)),
                $signed($urandom_range(0, 20 * 65536)) - 32'sh000A0000,
                5'($urandom_range(0, 20)));
      if (ph % 3 == 1) add_drain();
      random_block(20);
    end

    // Short ascending beat run, then strided queries over it
    gap = 0;
    load_regs(ltq_pkg::SRC_BEAT, 10'd1023, 10'd0, 16'h0, 4'h0, 31'd65536, 32'h0, 5'd16);
    add_op(ltq_pkg::OP_CLEAR, 32'sh0);
    for (int j = 0; j < 10; j++) add_op(ltq_pkg::OP_APP_BT, 32'(j * 4096 - 32'sh01000000));
    add_op(ltq_pkg::OP_QUERY, 32'sh7FFFFFFF);
    add_op(ltq_pkg::OP_QUERY, 32'sh80000000);
    load_regs(ltq_pkg::SRC_BEAT, 10'd7, 10'd1023, 16'h0, 4'h0, 31'd65536, 32'h0, 5'd16);
    add_op(ltq_pkg::OP_QUERY, 32'sh7FFFFFFF);
    load_regs(ltq_pkg::SRC_BEAT, 10'd5, 10'd3, 16'h0, 4'h0, 31'd65536, 32'h0, 5'd16);
    add_op(ltq_pkg::OP_QUERY, 32'sh7FFFFFFF);
    add_op(ltq_pkg::OP_QUERY, $urandom);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_items.size() == 0 && drv_state == D_IDLE && expected_fires.size() == 0);
    repeat (64) @(posedge clk);
    $display("Ran %0d queries, %0d appends, %0d register writes; %0d result beats, %0d found.",
             n_queries, n_appends, n_cfg, n_fires, n_found);
    if (errors == 0 && expected_fires.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ltq_pkg.sv
design/ltq_ram.sv
design/ltq_div.sv
design/ltq_dp.sv
design/ltq_ctrl.sv
design/last_trigger_time_query_core.sv
design/ltq_chk.sv
tb/last_trigger_time_query_core_test.sv
